>>> rtl/tcpws_pkg.sv
// Package for the TCP window-scale option matcher.
// Holds the parser constants, the phase and compare-mode types and the config indexes.
// No dependencies; every other file in rtl/ uses it.
`default_nettype none

package tcpws_pkg;

  // Header geometry.
  localparam int unsigned MAX_HEADER_BYTES = 60;
  localparam int unsigned BASE_HEADER      = 20;
  localparam int unsigned OFFSET_BYTE      = 12;
  localparam int unsigned POS_LIMIT        = 63;
  localparam int unsigned POS_W            = 6;
  localparam int unsigned HLEN_W           = 6;

  // Option codes.
  localparam logic [7:0] KIND_WINDOW = 8'd3;
  localparam logic [7:0] LEN_WINDOW  = 8'd3;
  localparam logic [7:0] LEN_MIN     = 8'd2;

  // Configuration port.
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_COMPARE_MODE    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_REFERENCE = 1'b1;

  // Option walk phase.
  typedef enum logic [1:0] {
    PH_KIND  = 2'd0,
    PH_LEN   = 2'd1,
    PH_VALUE = 2'd2,
    PH_SKIP  = 2'd3
  } phase_t;

  // Comparison applied to the found shift.
  typedef enum logic [1:0] {
    CMP_EQ = 2'd0,
    CMP_NE = 2'd1,
    CMP_LT = 2'd2,
    CMP_GT = 2'd3
  } cmp_mode_t;

endpackage

`default_nettype wire

>>> rtl/tcpws_if.sv
// Channel interfaces for the TCP window-scale option matcher.
// Segment byte input, result output and configuration write channels.
// Depends on tcpws_pkg for the configuration field widths.
`default_nettype none

// Segment bytes, one per transaction.
interface tcpws_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;
  logic       last_byte;

  modport source (output valid, output header_byte, output last_byte, input ready);
  modport sink   (input valid, input header_byte, input last_byte, output ready);
endinterface

// One result per segment.
interface tcpws_out_if;
  logic       valid;
  logic       ready;
  logic       matched;
  logic       drop;
  logic [7:0] scale_found;

  modport source (output valid, output matched, output drop, output scale_found,
                  input ready);
  modport sink   (input valid, input matched, input drop, input scale_found,
                  output ready);
endinterface

// Configuration register writes.
interface tcpws_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [tcpws_pkg::CFG_INDEX_W-1:0]    index;
  logic [tcpws_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/tcp_window_scale_option_match.sv
// Latency: a result is registered at the edge that accepts the last byte of a segment and is
// presented on the next cycle. Throughput: one byte per cycle; the parser state registers
// update once per accepted byte, and a byte stalls only while an untaken result sits in the
// output register. Reset (synchronous, active high) clears the parser, the output valid and
// both configuration registers (compare mode equal, reference zero).
// Depends on tcpws_pkg and the channel interfaces in tcpws_if.sv.
`default_nettype none

module tcp_window_scale_option_match (
  input  wire logic   clk,
  input  wire logic   rst,
  tcpws_in_if.sink    seg,
  tcpws_out_if.source res,
  tcpws_cfg_if.sink   cfg
);

  // Configuration registers.
  tcpws_pkg::cmp_mode_t compare_mode;
  logic [7:0]           scale_reference;

  // Parser state.
  logic [tcpws_pkg::POS_W-1:0]  byte_position, byte_position_next;
  logic [tcpws_pkg::HLEN_W-1:0] header_length, header_length_next;
  tcpws_pkg::phase_t            parse_phase, parse_phase_next;
  logic [7:0]                   skip_remaining, skip_remaining_next;
  logic [7:0]                   held_kind, held_kind_next;
  logic [7:0]                   scale_value, scale_value_next;
  logic                         scale_done, scale_done_next;

  // Result register.
  logic       res_valid;
  logic       res_matched;
  logic       res_drop;
  logic [7:0] res_scale;

  logic       seg_accept;
  logic [7:0] b;
  logic [tcpws_pkg::HLEN_W-1:0] hlen_cur;
  logic       walk_en;
  logic       window_fits;
  logic [7:0] skip_dec;
  logic       drop_now;
  logic       hit_now;

  assign seg.ready  = !res_valid || res.ready;
  assign seg_accept = seg.valid && seg.ready;
  assign b          = seg.header_byte;
  assign cfg.ready  = 1'b1;

  // Header length as seen by this byte (byte 12 supplies it).
  assign hlen_cur = (byte_position == tcpws_pkg::POS_W'(tcpws_pkg::OFFSET_BYTE)) ?
                    {b[7:4], 2'b00} : header_length;

  assign walk_en = (byte_position >= tcpws_pkg::POS_W'(tcpws_pkg::BASE_HEADER)) &&
                   (byte_position < hlen_cur) &&
                   (hlen_cur <= tcpws_pkg::HLEN_W'(tcpws_pkg::MAX_HEADER_BYTES)) &&
                   !scale_done;

  // The window option fits when its value byte lies inside the header.
  assign window_fits = ({1'b0, byte_position} + 7'd2) <= {1'b0, hlen_cur};
  assign skip_dec    = skip_remaining - {7'd0, (skip_remaining != 8'd0)};

  // Drop: short segment, bad or oversized offset, or truncated header.
  assign drop_now = (byte_position < tcpws_pkg::POS_W'(tcpws_pkg::BASE_HEADER - 1)) ||
                    (hlen_cur < tcpws_pkg::HLEN_W'(tcpws_pkg::BASE_HEADER)) ||
                    (hlen_cur > tcpws_pkg::HLEN_W'(tcpws_pkg::MAX_HEADER_BYTES)) ||
                    (({1'b0, byte_position} + 7'd1) < {1'b0, hlen_cur});

  // Next parser state for the byte on the input.
  always_comb begin
    byte_position_next  = byte_position;
    header_length_next  = hlen_cur;
    parse_phase_next    = parse_phase;
    skip_remaining_next = skip_remaining;
    held_kind_next      = held_kind;
    scale_value_next    = scale_value;
    scale_done_next     = scale_done;

    if (byte_position < tcpws_pkg::POS_W'(tcpws_pkg::POS_LIMIT)) begin
      byte_position_next = byte_position + 1'b1;
    end

    if (walk_en) begin
      case (parse_phase)
        tcpws_pkg::PH_KIND: begin
          if (b >= tcpws_pkg::LEN_MIN) begin
            held_kind_next   = b;
            parse_phase_next = tcpws_pkg::PH_LEN;
          end
        end
        tcpws_pkg::PH_LEN: begin
          if (held_kind == tcpws_pkg::KIND_WINDOW && b == tcpws_pkg::LEN_WINDOW &&
              window_fits) begin
            parse_phase_next = tcpws_pkg::PH_VALUE;
          end else if (b <= tcpws_pkg::LEN_MIN) begin
            parse_phase_next = tcpws_pkg::PH_KIND;
          end else begin
            skip_remaining_next = b - tcpws_pkg::LEN_MIN;
            parse_phase_next    = tcpws_pkg::PH_SKIP;
          end
        end
        tcpws_pkg::PH_VALUE: begin
          scale_value_next = b;
          scale_done_next  = 1'b1;
        end
        tcpws_pkg::PH_SKIP: begin
          skip_remaining_next = skip_dec;
          if (skip_dec == 8'd0) begin
            parse_phase_next = tcpws_pkg::PH_KIND;
          end
        end
        default: begin
          parse_phase_next = tcpws_pkg::PH_KIND;
        end
      endcase
    end
  end

  // Comparison of the shift found so far with the reference.
  always_comb begin
    case (compare_mode)
      tcpws_pkg::CMP_EQ: hit_now = scale_value_next == scale_reference;
      tcpws_pkg::CMP_NE: hit_now = scale_value_next != scale_reference;
      tcpws_pkg::CMP_LT: hit_now = scale_value_next <  scale_reference;
      tcpws_pkg::CMP_GT: hit_now = scale_value_next >  scale_reference;
      default:           hit_now = 1'b0;
    endcase
  end

  // Parser registers; the last byte returns the parser to its reset state.
  always_ff @(posedge clk) begin
    if (rst || (seg_accept && seg.last_byte)) begin
      byte_position  <= '0;
      header_length  <= '0;
      parse_phase    <= tcpws_pkg::PH_KIND;
      skip_remaining <= '0;
      held_kind      <= '0;
      scale_value    <= '0;
      scale_done     <= 1'b0;
    end else if (seg_accept) begin
      byte_position  <= byte_position_next;
      header_length  <= header_length_next;
      parse_phase    <= parse_phase_next;
      skip_remaining <= skip_remaining_next;
      held_kind      <= held_kind_next;
      scale_value    <= scale_value_next;
      scale_done     <= scale_done_next;
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (seg_accept && seg.last_byte) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (seg_accept && seg.last_byte) begin
      res_matched <= !drop_now && hit_now;
      res_drop    <= drop_now;
      res_scale   <= drop_now ? 8'd0 : scale_value_next;
    end
  end

  assign res.valid       = res_valid;
  assign res.matched     = res_matched;
  assign res.drop        = res_drop;
  assign res.scale_found = res_scale;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      compare_mode    <= tcpws_pkg::CMP_EQ;
      scale_reference <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        tcpws_pkg::CFG_COMPARE_MODE:    compare_mode    <= tcpws_pkg::cmp_mode_t'(cfg.data[1:0]);
        tcpws_pkg::CFG_SCALE_REFERENCE: scale_reference <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire
